/* hw/rtl/aes256_pkg.sv */
package aes256_pkg;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} in_req_t;

	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
		logic        from_finish;
	} out_req_t;

	localparam logic [1:0] CMD_ENC     = 2'd0;
	localparam logic [1:0] CMD_DEC     = 2'd1;
	localparam logic [1:0] CMD_FINISH  = 2'd2;
	localparam logic [1:0] CMD_DISCARD = 2'd3;

	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_KEY0    = 3'd1;
	localparam logic [2:0] REG_KEY3    = 3'd4;
	localparam logic [2:0] REG_IV_LOW  = 3'd5;
	localparam logic [2:0] REG_IV_HIGH = 3'd6;

	localparam int NUM_ROUNDS = 14;

	typedef struct packed {
		logic start;
		logic decrypt;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic keys_ready;
		logic busy;
		logic done;
	} dp_stat_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		gmul = p;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] inv;
		inv = 8'h01;
		for (int i = 0; i < 254; i++) inv = gmul(inv, x);
		if (x == 8'h00) inv = 8'h00;
		sbox = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
			^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] y);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 256; i++) begin
			if (sbox(8'(i)) == y) r = 8'(i);
		end
		inv_sbox = r;
	endfunction

	typedef logic [7:0] sbox_tab_t [256];

	function automatic sbox_tab_t make_sbox();
		sbox_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox(8'(i));
		make_sbox = t;
	endfunction

	function automatic sbox_tab_t make_inv_sbox();
		sbox_tab_t t;
		sbox_tab_t f;
		f = make_sbox();
		for (int i = 0; i < 256; i++) t[f[i]] = 8'(i);
		make_inv_sbox = t;
	endfunction

	localparam sbox_tab_t SBOX     = make_sbox();
	localparam sbox_tab_t INV_SBOX = make_inv_sbox();

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++) sub_word[8*i +: 8] = SBOX[w[8*i +: 8]];
	endfunction

	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
		logic [127:0] b;
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 16; c++) b[8*c +: 8] = SBOX[s[8*c +: 8]];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[8*(r+4*c) +: 8] = b[8*(r + 4*((c+r)%4)) +: 8];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[8*(4*c)   +: 8];
				a1 = t[8*(4*c+1) +: 8];
				a2 = t[8*(4*c+2) +: 8];
				a3 = t[8*(4*c+3) +: 8];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
				t[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
				t[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
				t[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		enc_round = t;
	endfunction

	function automatic logic [127:0] dec_round(input logic [127:0] s,
			input logic [127:0] k, input logic last);
		logic [127:0] t;
		logic [127:0] u;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[8*(r + 4*((c+r)%4)) +: 8] = s[8*(r+4*c) +: 8];
		for (int c = 0; c < 16; c++) u[8*c +: 8] = INV_SBOX[t[8*c +: 8]];
		u = u ^ k;
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = u[8*(4*c)   +: 8];
				a1 = u[8*(4*c+1) +: 8];
				a2 = u[8*(4*c+2) +: 8];
				a3 = u[8*(4*c+3) +: 8];
				u[8*(4*c)   +: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
					^ gmul(a3, 8'd9);
				u[8*(4*c+1) +: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
					^ gmul(a3, 8'd13);
				u[8*(4*c+2) +: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
					^ gmul(a3, 8'd11);
				u[8*(4*c+3) +: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
					^ gmul(a3, 8'd14);
			end
		end
		dec_round = u;
	endfunction

endpackage

/* hw/rtl/aes256_ram.sv */
module aes256_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 15
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/aes256_ctrl.sv */
module aes256_ctrl import aes256_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output ctl_cmd_t cmd,
	input  dp_stat_t stat,
	output logic     byte_we,
	output logic [3:0] byte_idx,
	output logic     res_load
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [3:0] count_q;
	logic       accept;
	logic       needs_block;

	assign accept = in_valid && !in_stall;
	assign needs_block = (in_data.cmd == CMD_FINISH) ||
		((in_data.cmd inside {CMD_ENC, CMD_DEC}) && count_q == 4'd15);

	// hold input while the round keys are not ready, a block runs or its result is still waiting
	assign in_stall = (state_q == ST_RUN) || (state_q == ST_OUT && out_stall) ||
		!stat.keys_ready;
	assign out_valid = (state_q == ST_OUT);

	assign byte_we  = accept && (in_data.cmd inside {CMD_ENC, CMD_DEC});
	assign byte_idx = count_q;
	assign cmd.start   = accept && needs_block;
	assign cmd.decrypt = in_data.cmd == CMD_DEC;
	assign cmd.finish  = in_data.cmd == CMD_FINISH;
	assign res_load = (state_q == ST_RUN) && stat.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= 4'd0;
		end else begin
			if (accept) begin
				if (in_data.cmd inside {CMD_ENC, CMD_DEC})
					count_q <= count_q + 4'd1;
				else
					count_q <= 4'd0;
			end
			case (state_q)
				ST_IDLE: if (cmd.start) state_q <= ST_RUN;
				ST_RUN:  if (stat.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_stall) state_q <= cmd.start ? ST_RUN : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/aes256_dp.sv */
module aes256_dp import aes256_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [63:0]  cfg_data,
	input  ctl_cmd_t     cmd,
	output dp_stat_t     stat,
	input  logic         byte_we,
	input  logic [3:0]   byte_idx,
	input  logic [7:0]   byte_data,
	input  logic         res_load,
	output out_req_t     result
);

	logic         mode_q;
	logic [255:0] key_q;
	logic [127:0] chain_q;
	logic [127:0] pend_q;
	logic [127:0] blk_in;

	// key expansion: one 128-bit round key per step, into a RAM
	logic         kx_busy_q;
	logic         keys_ok_q;
	logic [3:0]   kx_n_q;
	logic [127:0] kx_prev_q;
	logic [127:0] kx_cur_q;
	logic [6:0]   rcon_q;
	logic [127:0] kx_next;
	logic [31:0]  tw;
	logic [31:0]  nw [4];

	always_comb begin
		logic [31:0] t;
		t = kx_cur_q[127:96];
		if (!kx_n_q[0]) begin
			tw = sub_word({t[7:0], t[31:8]});
			tw[7:0] = tw[7:0] ^ {1'b0, rcon_q};
		end else begin
			tw = sub_word(t);
		end
		nw[0] = kx_prev_q[31:0] ^ tw;
		for (int i = 1; i < 4; i++) nw[i] = kx_prev_q[32*i +: 32] ^ nw[i-1];
		kx_next = {nw[3], nw[2], nw[1], nw[0]};
	end

	logic         rk_we;
	logic [3:0]   rk_waddr;
	logic [127:0] rk_wdata;
	logic [3:0]   rk_raddr;
	logic [127:0] rk_rdata;

	assign rk_we    = kx_busy_q;
	assign rk_waddr = kx_n_q;
	assign rk_wdata = kx_n_q == 4'd0 ? key_q[127:0] :
		(kx_n_q == 4'd1 ? key_q[255:128] : kx_next);

	aes256_ram #(.WIDTH(128), .DEPTH(NUM_ROUNDS + 1)) u_rk (
		.clk   (clk),
		.we    (rk_we),
		.waddr (rk_waddr),
		.wdata (rk_wdata),
		.raddr (rk_raddr),
		.rdata (rk_rdata)
	);

	// block engine
	logic         busy_q;
	logic         dec_q;
	logic         fin_q;
	logic [1:0]   phase_q;
	logic [3:0]   rnd_q;
	logic [127:0] st_q;
	logic [127:0] inblk_q;
	logic         done;

	always_comb begin
		blk_in = pend_q;
		if (byte_we) blk_in[8*byte_idx +: 8] = byte_data;
		if (cmd.finish) begin
			for (int i = 0; i < 16; i++) begin
				if (i == 32'(byte_idx)) blk_in[8*i +: 8] = 8'h01;
				else if (i > 32'(byte_idx)) blk_in[8*i +: 8] = 8'h00;
			end
		end
	end

	// phase 0 issues the read of a round key, phase 1 applies it
	assign rk_raddr = dec_q ? 4'(NUM_ROUNDS) - rnd_q : rnd_q;
	assign done = busy_q && phase_q == 2'd1 && rnd_q == 4'(NUM_ROUNDS);

	assign stat.keys_ready = keys_ok_q && !kx_busy_q;
	assign stat.busy = busy_q;
	assign stat.done = done;

	logic [127:0] fin_blk;
	always_comb begin
		if (!dec_q) fin_blk = enc_round(st_q, 1'b1) ^ rk_rdata;
		else fin_blk = dec_round(st_q, rk_rdata, 1'b1) ^ (mode_q ? chain_q : 128'h0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			key_q     <= '0;
			chain_q   <= '0;
			kx_busy_q <= 1'b1;
			keys_ok_q <= 1'b0;
			kx_n_q    <= 4'd0;
			kx_prev_q <= '0;
			kx_cur_q  <= '0;
			rcon_q    <= 7'h01;
			busy_q    <= 1'b0;
			phase_q   <= 2'd0;
			rnd_q     <= 4'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_MODE) mode_q <= cfg_data[0];
				if (cfg_idx inside {[REG_KEY0:REG_KEY3]}) begin
					key_q[64*(cfg_idx - REG_KEY0) +: 64] <= cfg_data;
					kx_busy_q <= 1'b1;
					kx_n_q    <= 4'd0;
					rcon_q    <= 7'h01;
				end
				if (cfg_idx == REG_IV_LOW)  chain_q[63:0]   <= cfg_data;
				if (cfg_idx == REG_IV_HIGH) chain_q[127:64] <= cfg_data;
			end else if (kx_busy_q) begin
				kx_prev_q <= kx_cur_q;
				kx_cur_q  <= rk_wdata;
				kx_n_q    <= kx_n_q + 4'd1;
				if (kx_n_q >= 4'd2 && !kx_n_q[0]) rcon_q <= {rcon_q[5:0], 1'b0};
				if (kx_n_q == 4'(NUM_ROUNDS)) begin
					kx_busy_q <= 1'b0;
					keys_ok_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
				rnd_q   <= 4'd0;
			end else if (busy_q) begin
				if (phase_q == 2'd0) begin
					phase_q <= 2'd1;
				end else if (rnd_q == 4'(NUM_ROUNDS)) begin
					busy_q <= 1'b0;
					if (mode_q) chain_q <= dec_q ? inblk_q : fin_blk;
				end else begin
					phase_q <= 2'd0;
					rnd_q   <= rnd_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_we) pend_q[8*byte_idx +: 8] <= byte_data;
		if (cmd.start) begin
			dec_q   <= cmd.decrypt;
			fin_q   <= cmd.finish;
			inblk_q <= blk_in;
			st_q    <= (!cmd.decrypt && mode_q) ? blk_in ^ chain_q : blk_in;
		end else if (busy_q && phase_q == 2'd1 && rnd_q != 4'(NUM_ROUNDS)) begin
			if (rnd_q == 4'd0) st_q <= st_q ^ rk_rdata;
			else if (!dec_q) st_q <= enc_round(st_q, 1'b0) ^ rk_rdata;
			else st_q <= dec_round(st_q, rk_rdata, 1'b0);
		end
		if (res_load) begin
			result.block_low   <= fin_blk[63:0];
			result.block_high  <= fin_blk[127:64];
			result.from_finish <= fin_q;
		end
	end

endmodule

/* hw/rtl/aes256_ecb_cbc_byte_engine.sv */
// AES-256 byte engine, ECB or CBC. Bytes are taken one per cycle, while input
// is not stalled, into a 16-byte buffer; the byte that completes a block, or a
// finish command, starts the cipher: the initial key addition and the 14 rounds
// each take a round key RAM read, then the round, during which input is stalled.
// The result then sits in the output register and input stays stalled while the
// result is held off; the next request can be taken in the cycle the result
// leaves. Writing a key register restarts the key expansion, input stalled until
// it ends; it also runs once after reset.
// Configure only while idle.
module aes256_ecb_cbc_byte_engine import aes256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_req_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_req_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	ctl_cmd_t   cmd;
	dp_stat_t   stat;
	logic       byte_we;
	logic [3:0] byte_idx;
	logic       res_load;

	assign cfg_ready = 1'b1;

	aes256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat),
		.byte_we   (byte_we),
		.byte_idx  (byte_idx),
		.res_load  (res_load)
	);

	aes256_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.byte_we   (byte_we),
		.byte_idx  (byte_idx),
		.byte_data (in_data.data_byte),
		.res_load  (res_load),
		.result    (out_data)
	);

endmodule

/* hw/rtl/aes256_checker.sv */
module aes256_checker import aes256_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input in_req_t  in_data,
	input logic     out_valid,
	input logic     out_stall,
	input out_req_t out_data
);

	// a discard never produces a result
	a_no_out_after_discard: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd == CMD_DISCARD && !out_valid |=> !out_valid)
		else $error("result without block");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_stall_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result waits");

endmodule

bind aes256_ecb_cbc_byte_engine aes256_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
	import aes256_pkg::*;

	typedef logic [7:0] blk_t [16];

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_req_t     in_data;
	logic        out_valid;
	logic        out_stall;
	out_req_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	aes256_ecb_cbc_byte_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [7:0]  fwd_sb [256];
	logic [7:0]  inv_sb [256];
	logic        cbc_mode;
	logic [63:0] key_reg [4];
	logic [63:0] chain [2];
	logic [7:0]  pend [16];
	int          pend_cnt;
	logic [7:0]  sched [240];
	logic        sched_ok;

	in_req_t  byte_q [$];
	out_req_t block_expect [$];
	int       errors;
	int       n_blocks, n_finish, n_req;
	int       cycles;
	int       gap_max, stall_pct;
	int       gap_left, burst_left;
	int       hold_cnt;
	logic     hold_req;
	logic     in_taken;

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = xt(a);
		end
		return p;
	endfunction

	task automatic build_sboxes();
		logic [7:0] v;
		for (int x = 0; x < 256; x++) begin
			v = 8'h01;
			for (int i = 0; i < 254; i++) v = gf_mul(v, 8'(x));
			if (x == 0) v = 8'h00;
			fwd_sb[x] = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
				^ {v[3:0], v[7:4]} ^ 8'h63;
		end
		for (int x = 0; x < 256; x++) inv_sb[fwd_sb[x]] = 8'(x);
	endtask

	task automatic expand_schedule();
		logic [7:0] t [4];
		logic [7:0] tmp;
		logic [7:0] rc [7];
		rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
		for (int i = 0; i < 32; i++) sched[i] = key_reg[i / 8][8 * (i % 8) +: 8];
		for (int i = 8; i < 60; i++) begin
			for (int j = 0; j < 4; j++) t[j] = sched[4 * (i - 1) + j];
			if (i % 8 == 0) begin
				tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
				for (int j = 0; j < 4; j++) t[j] = fwd_sb[t[j]];
				t[0] ^= rc[i / 8 - 1];
			end else if (i % 8 == 4) begin
				for (int j = 0; j < 4; j++) t[j] = fwd_sb[t[j]];
			end
			for (int j = 0; j < 4; j++) sched[4 * i + j] = sched[4 * (i - 8) + j] ^ t[j];
		end
		sched_ok = 1'b1;
	endtask

	function automatic blk_t add_round_key(input blk_t s, input int rnd);
		for (int j = 0; j < 16; j++) s[j] ^= sched[16 * rnd + j];
		return s;
	endfunction

	function automatic blk_t cipher_fwd(input blk_t s);
		blk_t t;
		logic [7:0] a0, a1, a2, a3, al;
		s = add_round_key(s, 0);
		for (int r = 1; r <= 14; r++) begin
			for (int c = 0; c < 16; c++) s[c] = fwd_sb[s[c]];
			for (int c = 0; c < 4; c++)
				for (int w = 0; w < 4; w++) t[w + 4 * c] = s[w + 4 * ((c + w) % 4)];
			s = t;
			if (r != 14) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					s[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
					s[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
					s[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
					s[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
				end
			end
			s = add_round_key(s, r);
		end
		return s;
	endfunction

	function automatic blk_t cipher_inv(input blk_t s);
		blk_t t;
		logic [7:0] a0, a1, a2, a3;
		s = add_round_key(s, 14);
		for (int r = 1; r <= 14; r++) begin
			for (int c = 0; c < 4; c++)
				for (int w = 0; w < 4; w++) t[w + 4 * ((c + w) % 4)] = s[w + 4 * c];
			for (int c = 0; c < 16; c++) s[c] = inv_sb[t[c]];
			s = add_round_key(s, 14 - r);
			if (r != 14) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					s[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
						^ gf_mul(a3, 8'd9);
					s[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
						^ gf_mul(a3, 8'd13);
					s[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
						^ gf_mul(a3, 8'd11);
					s[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
						^ gf_mul(a3, 8'd14);
				end
			end
		end
		return s;
	endfunction

	task automatic crypt_block(input blk_t b, input logic dec, input logic fin);
		blk_t cv;
		blk_t src;
		out_req_t o;
		if (!sched_ok) expand_schedule();
		for (int j = 0; j < 16; j++) cv[j] = chain[j / 8][8 * (j % 8) +: 8];
		src = b;
		if (!dec) begin
			if (cbc_mode) for (int j = 0; j < 16; j++) b[j] ^= cv[j];
			b = cipher_fwd(b);
			if (cbc_mode) for (int j = 0; j < 16; j++) chain[j / 8][8 * (j % 8) +: 8] = b[j];
		end else begin
			b = cipher_inv(b);
			if (cbc_mode) begin
				for (int j = 0; j < 16; j++) b[j] ^= cv[j];
				for (int j = 0; j < 16; j++) chain[j / 8][8 * (j % 8) +: 8] = src[j];
			end
		end
		for (int j = 0; j < 8; j++) begin
			o.block_low[8 * j +: 8] = b[j];
			o.block_high[8 * j +: 8] = b[j + 8];
		end
		o.from_finish = fin;
		block_expect.insert(block_expect.size(), o);
	endtask

	task automatic engine_step(input in_req_t r);
		blk_t b;
		case (r.cmd)
			CMD_DISCARD: begin
				pend_cnt = 0;
			end
			CMD_FINISH: begin
				for (int j = 0; j < 16; j++) b[j] = (j < pend_cnt) ? pend[j] : 8'h00;
				b[pend_cnt] = 8'h01;
				pend_cnt = 0;
				crypt_block(b, 1'b0, 1'b1);
			end
			default: begin
				pend[pend_cnt] = r.data_byte;
				if (pend_cnt < 15) begin
					pend_cnt++;
				end else begin
					pend_cnt = 0;
					b = pend;
					crypt_block(b, r.cmd == CMD_DEC, 1'b0);
				end
			end
		endcase
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		errors++;
		$display("tb: mismatch %s got %h want %h at %0t", what, got, exp, $realtime);
	endtask

	task automatic add_req(input in_req_t r);
		byte_q.insert(byte_q.size(), r);
	endtask

	always #5 clk = ~clk;

	// request acceptance, predictor and result checking
	always @(posedge clk) begin
		out_req_t e;
		cycles++;
		if (cycles > 600000) begin
			$display("tb: timeout");
			$display("tb: done, errors");
			$finish;
		end
		if (in_valid && !in_stall) begin
			in_taken = 1'b1;
			n_req++;
			engine_step(in_data);
		end
		if (out_valid && !out_stall) begin
			if (block_expect.size() == 0) begin
				report("unexpected block", out_data.block_low, 64'h0);
			end else begin
				e = block_expect.pop_front();
				n_blocks++;
				if (e.from_finish) n_finish++;
				if (out_data.block_low !== e.block_low)
					report("block_low", out_data.block_low, e.block_low);
				if (out_data.block_high !== e.block_high)
					report("block_high", out_data.block_high, e.block_high);
				if (out_data.from_finish !== e.from_finish)
					report("from_finish", 64'(out_data.from_finish), 64'(e.from_finish));
			end
		end
	end

	// sender: bursts with gaps
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (byte_q.size() > 0) begin
			in_data <= byte_q.pop_front();
			in_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				gap_left = $urandom_range(0, gap_max);
			end else begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
		end
		in_taken = 1'b0;
	end

	// receiver: random stall, long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 400;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_MODE: cbc_mode = val[0];
			REG_IV_LOW, REG_IV_HIGH: chain[idx - REG_IV_LOW] = val;
			default: begin
				if (idx >= REG_KEY0 && idx <= REG_KEY3) begin
					key_reg[idx - REG_KEY0] = val;
					sched_ok = 1'b0;
				end
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(input logic m, input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] ivl,
			input logic [63:0] ivh);
		cfg_write(REG_MODE, {63'h0, m});
		cfg_write(REG_KEY0, k0);
		cfg_write(REG_KEY0 + 3'd1, k1);
		cfg_write(REG_KEY0 + 3'd2, k2);
		cfg_write(REG_KEY3, k3);
		cfg_write(REG_IV_LOW, ivl);
		cfg_write(REG_IV_HIGH, ivh);
	endtask

	task automatic drain();
		@(negedge clk);
		while (byte_q.size() != 0 || in_valid || block_expect.size() != 0) @(negedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic in_req_t mk(input logic [1:0] c, input logic [7:0] d);
		in_req_t r;
		r.cmd = c;
		r.data_byte = d;
		return r;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// mostly whole blocks of one direction, some mixed, finishes and discards
	task automatic fill_random(input int count);
		int k, len;
		logic [1:0] dir;
		k = 0;
		while (k < count) begin
			dir = $urandom_range(0, 1) ? CMD_DEC : CMD_ENC;
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 16;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0) dir = ~dir[0] ? CMD_DEC : CMD_ENC;
				add_req(mk(dir, 8'($urandom)));
				k++;
			end
			case ($urandom_range(0, 9))
				0, 1: begin add_req(mk(CMD_FINISH, 8'($urandom))); k++; end
				2: begin add_req(mk(CMD_DISCARD, 8'($urandom))); k++; end
				default: ;
			endcase
		end
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		errors = 0; n_blocks = 0; n_finish = 0; n_req = 0; cycles = 0;
		gap_max = 0; stall_pct = 0; gap_left = 0; burst_left = 1;
		hold_cnt = 0; hold_req = 1'b0; in_taken = 1'b0;
		cbc_mode = 0; pend_cnt = 0; sched_ok = 1'b0;
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		chain[0] = '0; chain[1] = '0;
		for (int i = 0; i < 16; i++) pend[i] = '0;
		build_sboxes();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed, reset configuration
		for (int i = 0; i < 15; i++) add_req(mk(CMD_ENC, 8'hff));
		add_req(mk(CMD_FINISH, 8'h00));
		add_req(mk(CMD_FINISH, 8'hff));
		for (int i = 0; i < 3; i++) add_req(mk(CMD_DEC, 8'h00));
		add_req(mk(CMD_DISCARD, 8'hff));
		add_req(mk(CMD_DEC, 8'h5a));
		add_req(mk(CMD_FINISH, 8'h00));
		for (int i = 0; i < 16; i++) add_req(mk(i[0] ? CMD_ENC : CMD_DEC, 8'(i)));
		drain();

		gap_max = 6; stall_pct = 30;
		setup(1'b1, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
		fill_random(500);
		drain();

		// back-pressure: receiver holds while sender runs flat out
		gap_max = 0; stall_pct = 0;
		setup(1'b0, '1, '1, '1, '1, '1, '1);
		hold_req = 1'b1;
		fill_random(450);
		drain();

		gap_max = 3; stall_pct = 60;
		setup(1'b1, '0, '0, '0, '0, '0, '0);
		fill_random(500);
		drain();

		gap_max = 10; stall_pct = 15;
		setup(1'b1, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
		cfg_write(3'd7, rnd64());
		fill_random(500);
		drain();

		$display("tb: %0d requests accepted, %0d blocks checked (%0d padded final)",
			n_req, n_blocks, n_finish);
		$display("tb: ECB and CBC, extreme and random keys, mixed directions, stalls");
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
